>>> hdl/bcmm_pkg.sv
// Package for the banked cartridge memory mapper: sizes, address map constants,
// function codes, the memory command struct and bank wrap tables.
// No dependencies.
`default_nettype none

package bcmm_pkg;

  localparam int ROM_BANKS = 8;
  localparam int RAM_BANKS = 4;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_DEPTH      = ROM_BANKS * ROM_BANK_BYTES;
  localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
  localparam int ROM_BW         = $clog2(ROM_BANKS);
  localparam int RAM_BW         = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int ROM_AW         = ROM_BW + 14;
  localparam int RAM_AW         = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) + 13 : 13;

  localparam logic [15:0] ADDR_ROM_BANK  = 16'h2000;
  localparam logic [15:0] ADDR_BANKED    = 16'h4000;
  localparam logic [15:0] ADDR_MODE      = 16'h6000;
  localparam logic [15:0] ADDR_ROM_END   = 16'h8000;
  localparam logic [15:0] ADDR_RAM       = 16'hA000;
  localparam logic [15:0] ADDR_RAM_END   = 16'hC000;

  localparam logic [3:0] RAM_EN_KEY    = 4'hA;
  localparam logic [4:0] ROM_LOW_MASK  = 5'h1F;
  localparam logic [1:0] UPPER_MASK    = 2'h3;
  localparam logic [4:0] ROM_LOW_MIN   = 5'h01;
  localparam logic [7:0] OPEN_BUS      = 8'hFF;

  localparam logic [1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [1:0] CFG_RAM_PRESENT = 2'd1;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_LOAD  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    SRC_OPEN = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2
  } src_e;

  typedef struct packed {
    logic              rd;
    src_e              src;
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        wdata;
  } mem_cmd_t;

  function automatic logic [ROM_BW-1:0] rom_bank_wrap(input logic [6:0] bank);
    logic [ROM_BW-1:0] r;
    r = '0;
    for (int i = 0; i < 128; i++) begin
      if (bank == 7'(i)) r = ROM_BW'(i % ROM_BANKS);
    end
    return r;
  endfunction

  function automatic logic [RAM_BW-1:0] ram_page_wrap(input logic [1:0] bank);
    logic [RAM_BW-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      if (bank == 2'(i)) r = RAM_BW'(i % RAM_BANKS);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/banked_cartridge_memory_mapper_unit.sv
// Top level of the banked cartridge memory mapper: ROM and RAM arrays, read
// return path and output register with skid. Depends on bcmm_pkg, bcmm_ctrl.
//
// channel  direction  handshake              payload
// in       sink       in_valid_i/in_stall_o  func, bus_address, bus_data, rom_offset
// out      source     out_valid_o/out_stall_i read_data
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index, cfg_data
//
// Writes and loads complete at the accepting edge; a read's word passes
// through the array read port register, then the output register, or the
// skid register when the output is stalled.
// Input stalls in the cycle after each accepted read, and while a returned
// word sits in the skid register behind a stalled output.
// Reset returns bank and configuration registers to their defaults; arrays are not cleared.
`default_nettype none

module banked_cartridge_memory_mapper_unit import bcmm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] bus_address_i,
  input  wire logic [7:0]  bus_data_i,
  input  wire logic [16:0] rom_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o
);

  mem_cmd_t cmd;
  logic     accept;
  logic     take;

  logic [7:0] rom_mem [ROM_DEPTH];
  logic [7:0] ram_mem [RAM_DEPTH];
  logic [7:0] rom_rd_q;
  logic [7:0] ram_rd_q;
  logic [7:0] rd_data;

  logic       rd_pend_q;
  src_e       rd_src_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       skid_valid_q;
  logic [7:0] skid_data_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = rd_pend_q | skid_valid_q;
  assign accept      = in_valid_i & ~in_stall_o;
  assign take        = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  bcmm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .func_i        (func_i),
    .bus_address_i (bus_address_i),
    .bus_data_i    (bus_data_i),
    .rom_offset_i  (rom_offset_i),
    .cmd_o         (cmd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd.rom_we) rom_mem[cmd.rom_addr] <= cmd.wdata;
    if (cmd.rd)     rom_rd_q <= rom_mem[cmd.rom_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd.ram_we) ram_mem[cmd.ram_addr] <= cmd.wdata;
    if (cmd.rd)     ram_rd_q <= ram_mem[cmd.ram_addr];
  end

  always_comb begin
    case (rd_src_q)
      SRC_ROM: rd_data = rom_rd_q;
      SRC_RAM: rd_data = ram_rd_q;
      default: rd_data = OPEN_BUS;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd.rd) rd_src_q <= cmd.src;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd.rd;
      if (skid_valid_q) begin
        if (take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (rd_pend_q) begin
        if (!out_valid_q || take) out_valid_q <= 1'b1;
        else                      skid_valid_q <= 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) out_data_q <= skid_data_q;
    end else if (rd_pend_q) begin
      if (!out_valid_q || take) out_data_q <= rd_data;
      else                      skid_data_q <= rd_data;
    end
  end

`ifndef SYNTHESIS
  a_pend_skid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_pend_q && skid_valid_q))
    else $error("read returned while skid register full");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full with empty output register");

  a_read_issues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_READ) |=> rd_pend_q)
    else $error("accepted read did not issue");

  a_no_spurious_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i != FUNC_READ) |=> !rd_pend_q)
    else $error("non-read word produced a read");
`endif

endmodule

`default_nettype wire

>>> hdl/bcmm_ctrl.sv
// Bank control registers, configuration registers and bus address decode.
// Produces one memory command per accepted word. Depends on bcmm_pkg.
`default_nettype none

module bcmm_ctrl import bcmm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic        cfg_data_i,
  input  wire logic        accept_i,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] bus_address_i,
  input  wire logic [7:0]  bus_data_i,
  input  wire logic [16:0] rom_offset_i,
  output mem_cmd_t         cmd_o
);

  logic       mapper_kind_q, mapper_kind_d;
  logic       ram_present_q, ram_present_d;
  logic       ram_enable_q, ram_enable_d;
  logic [4:0] rom_low_q, rom_low_d;
  logic [1:0] bank_upper_q, bank_upper_d;
  logic       mode_q, mode_d;

  logic [4:0]        low;
  logic [ROM_BW-1:0] rom_bank;
  logic [RAM_BW-1:0] ram_page;
  logic              ram_on;
  logic              in_ram;

  assign low      = (rom_low_q != 5'd0) ? rom_low_q : ROM_LOW_MIN;
  assign rom_bank = rom_bank_wrap({bank_upper_q, low});
  assign ram_page = mode_q ? ram_page_wrap(bank_upper_q) : '0;
  assign ram_on   = ram_enable_q & ram_present_q;
  assign in_ram   = (bus_address_i >= ADDR_RAM) && (bus_address_i < ADDR_RAM_END);

  always_comb begin
    mapper_kind_d = mapper_kind_q;
    ram_present_d = ram_present_q;
    ram_enable_d  = ram_enable_q;
    rom_low_d     = rom_low_q;
    bank_upper_d  = bank_upper_q;
    mode_d        = mode_q;

    cmd_o.rd       = 1'b0;
    cmd_o.src      = SRC_OPEN;
    cmd_o.rom_we   = 1'b0;
    cmd_o.rom_addr = '0;
    cmd_o.ram_we   = 1'b0;
    cmd_o.ram_addr = RAM_AW'({ram_page, bus_address_i[12:0]});
    cmd_o.wdata    = bus_data_i;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAPPER_KIND: mapper_kind_d = cfg_data_i;
        CFG_RAM_PRESENT: ram_present_d = cfg_data_i;
        default: ;
      endcase
    end

    if (accept_i) begin
      case (func_i)
        FUNC_READ: begin
          cmd_o.rd = 1'b1;
          if (!mapper_kind_q) begin
            if (bus_address_i < ADDR_ROM_END) begin
              cmd_o.src      = SRC_ROM;
              cmd_o.rom_addr = ROM_AW'(bus_address_i[14:0]);
            end
          end else if (bus_address_i < ADDR_BANKED) begin
            cmd_o.src      = SRC_ROM;
            cmd_o.rom_addr = ROM_AW'(bus_address_i[13:0]);
          end else if (bus_address_i < ADDR_ROM_END) begin
            cmd_o.src      = SRC_ROM;
            cmd_o.rom_addr = {rom_bank, bus_address_i[13:0]};
          end else if (in_ram && ram_on) begin
            cmd_o.src = SRC_RAM;
          end
        end
        FUNC_WRITE: begin
          if (mapper_kind_q) begin
            if (bus_address_i < ADDR_ROM_BANK) begin
              ram_enable_d = (bus_data_i[3:0] == RAM_EN_KEY);
            end else if (bus_address_i < ADDR_BANKED) begin
              rom_low_d = bus_data_i[4:0] & ROM_LOW_MASK;
              if (rom_low_d == 5'd0) rom_low_d = ROM_LOW_MIN;
            end else if (bus_address_i < ADDR_MODE) begin
              bank_upper_d = bus_data_i[1:0] & UPPER_MASK;
            end else if (bus_address_i < ADDR_ROM_END) begin
              mode_d = bus_data_i[0];
            end else if (in_ram && ram_on) begin
              cmd_o.ram_we = 1'b1;
            end
          end
        end
        FUNC_LOAD: begin
          if (32'(rom_offset_i) < ROM_DEPTH) begin
            cmd_o.rom_we   = 1'b1;
            cmd_o.rom_addr = ROM_AW'(rom_offset_i);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapper_kind_q <= 1'b1;
      ram_present_q <= 1'b1;
      ram_enable_q  <= 1'b0;
      rom_low_q     <= ROM_LOW_MIN;
      bank_upper_q  <= 2'd0;
      mode_q        <= 1'b0;
    end else begin
      mapper_kind_q <= mapper_kind_d;
      ram_present_q <= ram_present_d;
      ram_enable_q  <= ram_enable_d;
      rom_low_q     <= rom_low_d;
      bank_upper_q  <= bank_upper_d;
      mode_q        <= mode_d;
    end
  end

endmodule

`default_nettype wire
